/* hdl/bole_pkg.sv */
package bole_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int ELEM_W = 32;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_POS  = 3'd5,
    OP_READ     = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BOUND = 2'd2,
    ST_FULL  = 2'd3
  } stat_e;

  typedef struct packed {
    logic exec;
    logic rd_emit;
  } cmd_t;

  typedef struct packed {
    logic rd_go;
    logic rd_last;
  } sts_t;

  function automatic logic [DATA_WIDTH-1:0] to_cell(input logic [VAL_W-1:0] v);
    return DATA_WIDTH'(v);
  endfunction

  function automatic logic [ELEM_W-1:0] to_elem(input logic [DATA_WIDTH-1:0] c);
    logic signed [63:0] ext;
    ext = 64'(signed'(c));
    return ext[ELEM_W-1:0];
  endfunction

endpackage

/* hdl/bole_ctrl.sv */
module bole_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  bole_pkg::sts_t sts_i,
  output bole_pkg::cmd_t cmd_o,
  output logic          busy
);
  import bole_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e state_q;
  logic   busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start && sts_i.rd_go) begin
            state_q <= S_READ;
            busy_q  <= 1'b1;
          end
        end
        S_READ: begin
          if (sts_i.rd_last) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o.exec    = start && (state_q == S_IDLE);
  assign cmd_o.rd_emit = (state_q == S_READ);
  assign busy          = busy_q;

endmodule

/* hdl/bole_dp.sv */
module bole_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bole_pkg::cmd_t                     cmd_i,
  output bole_pkg::sts_t                     sts_o,
  input  logic [bole_pkg::OP_W-1:0]          op_i,
  input  logic signed [bole_pkg::VAL_W-1:0]  value_i,
  input  logic [bole_pkg::POS_W-1:0]         position_i,
  output logic                               strobe_o,
  output logic [bole_pkg::STAT_W-1:0]        status_o,
  output logic signed [bole_pkg::ELEM_W-1:0] element_o,
  output logic                               last_o
);
  import bole_pkg::*;

  logic [DATA_WIDTH-1:0] cells_q [CAPACITY];
  logic [DATA_WIDTH-1:0] cells_d [CAPACITY];
  logic [DATA_WIDTH-1:0] up     [CAPACITY];
  logic [DATA_WIDTH-1:0] dn     [CAPACITY];
  logic [DATA_WIDTH-1:0] new_cell;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  strobe_q, strobe_d;
  logic                  last_q, last_d;
  stat_e                 status_q, status_d;
  logic [ELEM_W-1:0]     element_q, element_d;

  op_e              op;
  stat_e            st;
  logic             do_ins, do_del;
  logic [CMP_W-1:0] at, pos_x, cnt_x;
  logic             full, empty;

  assign op       = op_e'(op_i);
  assign pos_x    = CMP_W'(position_i);
  assign cnt_x    = CMP_W'(count_q);
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign new_cell = to_cell(value_i);

  always_comb begin
    st     = ST_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    at     = '0;
    unique case (op)
      OP_INS_HEAD: begin
        if (full) st = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_TAIL: begin
        if (full) st = ST_FULL;
        else begin
          do_ins = 1'b1;
          at     = cnt_x;
        end
      end
      OP_INS_POS: begin
        if (full) st = ST_FULL;
        else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) st = ST_BOUND;
        else begin
          do_ins = 1'b1;
          at     = pos_x - CMP_W'(1);
        end
      end
      OP_DEL_HEAD: begin
        if (empty) st = ST_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_TAIL: begin
        if (empty) st = ST_EMPTY;
        else begin
          do_del = 1'b1;
          at     = cnt_x - CMP_W'(1);
        end
      end
      OP_DEL_POS: begin
        if (empty) st = ST_EMPTY;
        else if (pos_x == '0 || pos_x > cnt_x) st = ST_BOUND;
        else begin
          do_del = 1'b1;
          at     = pos_x - CMP_W'(1);
        end
      end
      OP_READ: begin
        if (empty) st = ST_EMPTY;
      end
      default: st = ST_BOUND;
    endcase
  end

  assign sts_o.rd_go   = (op == OP_READ) && !empty;
  assign sts_o.rd_last = (CNT_W'(rd_idx_q) + CNT_W'(1) == count_q);

  // neighbor taps for the one-step shift
  always_comb begin
    up[0]          = cells_q[0];
    dn[CAPACITY-1] = cells_q[CAPACITY-1];
    for (int i = 1; i < CAPACITY; i++) begin
      up[i]   = cells_q[i-1];
      dn[i-1] = cells_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_d[i] = cells_q[i];
      if (cmd_i.exec && do_ins) begin
        if (CMP_W'(i) == at) cells_d[i] = new_cell;
        else if (CMP_W'(i) > at) cells_d[i] = up[i];
      end else if (cmd_i.exec && do_del) begin
        if (CMP_W'(i) >= at) cells_d[i] = dn[i];
      end
    end
  end

  always_comb begin
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    strobe_d  = 1'b0;
    status_d  = status_q;
    element_d = element_q;
    last_d    = last_q;
    if (cmd_i.exec) begin
      if (do_ins) count_d = count_q + CNT_W'(1);
      if (do_del) count_d = count_q - CNT_W'(1);
      if (!sts_o.rd_go) begin
        strobe_d  = 1'b1;
        status_d  = st;
        element_d = '0;
        last_d    = 1'b1;
      end
    end
    if (cmd_i.rd_emit) begin
      strobe_d  = 1'b1;
      status_d  = ST_OK;
      element_d = to_elem(cells_q[rd_idx_q]);
      last_d    = sts_o.rd_last;
      rd_idx_d  = sts_o.rd_last ? '0 : rd_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    element_q <= element_d;
    last_q    <= last_d;
    for (int i = 0; i < CAPACITY; i++) begin
      cells_q[i] <= cells_d[i];
    end
  end

  assign strobe_o  = strobe_q;
  assign status_o  = status_q;
  assign element_o = signed'(element_q);
  assign last_o    = last_q;

endmodule

/* hdl/bounded_ordered_list_engine_core.sv */
// Edits: accepted when busy is low, result strobed next cycle; one edit per cycle.
// Read-out of N elements: busy while read, N results strobed on consecutive cycles, the
// first after state and output registers; an empty list gives one result next cycle.
// The read-out rate is set by the single cell read port, one element per cycle.
// Results cannot be stalled. Reset (async, active low) empties the list; cells hold
// no defined value until written.
module bounded_ordered_list_engine_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [bole_pkg::OP_W-1:0]          op_i,
  input  logic signed [bole_pkg::VAL_W-1:0]  value_i,
  input  logic [bole_pkg::POS_W-1:0]         position_i,
  output logic                               strobe_o,
  output logic [bole_pkg::STAT_W-1:0]        status_o,
  output logic signed [bole_pkg::ELEM_W-1:0] element_o,
  output logic                               last_o
);
  import bole_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bole_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  bole_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .op_i       (op_i),
    .value_i    (value_i),
    .position_i (position_i),
    .strobe_o   (strobe_o),
    .status_o   (status_o),
    .element_o  (element_o),
    .last_o     (last_o)
  );

endmodule

/* hdl/bole_chk.sv */
module bole_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               strobe_o,
  input logic [bole_pkg::STAT_W-1:0]        status_o,
  input logic signed [bole_pkg::ELEM_W-1:0] element_o,
  input logic                               last_o
);
  import bole_pkg::*;

  // an accepted item either answers next cycle or starts a read-out
  a_accept_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> strobe_o || busy)
    else $error("accepted item gave neither result nor busy");

  a_busy_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // only the final beat of an item shows up with busy low
  a_last_vs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (last_o == !busy))
    else $error("last flag disagrees with busy");

  a_readout_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("gap inside a read-out");

  a_err_zero_elem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o != ST_OK) |-> (element_o == '0))
    else $error("nonzero element on an error status");

endmodule

bind bounded_ordered_list_engine_core bole_chk u_bole_chk (.*);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import bole_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int RAND_ITEMS = 270;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_ROWS = 24;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ELEM_W-1:0] element;
    logic              last;
  } beat_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
    int unsigned      rep;
    logic             typed;
    stat_e            status;
  } dir_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [OP_W-1:0]          op_i;
  logic signed [VAL_W-1:0]  value_i;
  logic [POS_W-1:0]         position_i;
  logic                     strobe_o;
  logic [STAT_W-1:0]        status_o;
  logic signed [ELEM_W-1:0] element_o;
  logic                     last_o;

  logic [DATA_WIDTH-1:0] list_cells [CAPACITY];
  int                    list_len;
  beat_t                 list_responses [$];
  int unsigned           fail_count = 0;
  dir_row_t              dir_rows [NUM_ROWS];

  bounded_ordered_list_engine_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .op_i       (op_i),
    .value_i    (value_i),
    .position_i (position_i),
    .strobe_o   (strobe_o),
    .status_o   (status_o),
    .element_o  (element_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("bounded_ordered_list_engine_core test failed");
    $finish;
  end

  // updates the list copy and queues the beats this operation yields
  task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                               input logic [POS_W-1:0] position, input logic typed,
                               input stat_e typed_status);
    stat_e st;
    int    slot;
    int    i;
    logic  readout;
    st = ST_OK;
    slot = 0;
    readout = 1'b0;
    case (op)
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
        if (list_len >= CAPACITY) begin
          st = ST_FULL;
        end else if (op == OP_INS_POS && (position < 1 || position > list_len + 1)) begin
          st = ST_BOUND;
        end else begin
          slot = (op == OP_INS_HEAD) ? 0 : (op == OP_INS_TAIL) ? list_len : position - 1;
          for (i = list_len; i > slot; i--) list_cells[i] = list_cells[i-1];
          list_cells[slot] = value[DATA_WIDTH-1:0];
          list_len++;
        end
      end
      OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else if (op == OP_DEL_POS && (position < 1 || position > list_len)) begin
          st = ST_BOUND;
        end else begin
          slot = (op == OP_DEL_HEAD) ? 0 : (op == OP_DEL_TAIL) ? list_len - 1 : position - 1;
          for (i = slot; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (list_len == 0) st = ST_EMPTY;
        else readout = 1'b1;
      end
      default: st = ST_BOUND;
    endcase
    if (typed) begin
      list_responses.push_back('{status: typed_status, element: '0, last: 1'b1});
    end else if (readout) begin
      for (i = 0; i < list_len; i++)
        list_responses.push_back('{status: ST_OK,
                                   element: ELEM_W'(signed'(list_cells[i])),
                                   last: (i == list_len - 1)});
    end else begin
      list_responses.push_back('{status: st, element: '0, last: 1'b1});
    end
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                           input logic [POS_W-1:0] position, input logic typed,
                           input stat_e typed_status);
    start      <= 1'b1;
    op_i       <= op;
    value_i    <= value;
    position_i <= position;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_list_op(op, value, position, typed, typed_status);
  endtask

  task automatic idle_gap(input logic no_gap);
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (no_gap || r < 50) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (list_responses.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && strobe_o) begin
      if (list_responses.size() == 0) begin
        $display("%0t: unexpected beat: status %0d element %0h last %0b",
                 $time, status_o, element_o, last_o);
        fail_count++;
      end else begin
        want = list_responses.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          fail_count++;
        end
        if (element_o !== want.element) begin
          $display("%0t: element expected %0h actual %0h", $time, want.element, element_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int               k;
    int               j;
    int               n;
    int unsigned      r;
    logic             filling;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;

    start      <= 1'b0;
    op_i       <= '0;
    value_i    <= '0;
    position_i <= '0;
    rst_ni     <= 1'b0;
    list_len = 0;
    filling = 1'b1;

    dir_rows = '{
      '{OP_READ,     32'h0000_0000, 5'd0,  1,  1'b1, ST_EMPTY},
      '{OP_DEL_HEAD, 32'h0000_0000, 5'd0,  1,  1'b1, ST_EMPTY},
      '{OP_DEL_TAIL, 32'h0000_0000, 5'd0,  1,  1'b1, ST_EMPTY},
      '{OP_DEL_POS,  32'h0000_0000, 5'd1,  1,  1'b1, ST_EMPTY},
      '{OP_INS_POS,  32'h1234_5678, 5'd0,  1,  1'b1, ST_BOUND},
      '{OP_INS_POS,  32'h1234_5678, 5'd2,  1,  1'b1, ST_BOUND},
      '{OP_UNUSED,   32'h0000_0000, 5'd0,  1,  1'b1, ST_BOUND},
      '{OP_INS_HEAD, 32'h8000_0000, 5'd0,  1,  1'b1, ST_OK},
      '{OP_INS_TAIL, 32'h7FFF_FFFF, 5'd31, 1,  1'b1, ST_OK},
      '{OP_INS_POS,  32'hFFFF_FFFF, 5'd2,  1,  1'b1, ST_OK},
      '{OP_READ,     32'h0000_0000, 5'd0,  1,  1'b0, ST_OK},
      '{OP_DEL_POS,  32'h0000_0000, 5'd31, 1,  1'b1, ST_BOUND},
      '{OP_DEL_POS,  32'h0000_0000, 5'd4,  1,  1'b1, ST_BOUND},
      '{OP_DEL_POS,  32'h0000_0000, 5'd2,  1,  1'b1, ST_OK},
      '{OP_DEL_TAIL, 32'h0000_0000, 5'd0,  1,  1'b1, ST_OK},
      '{OP_DEL_HEAD, 32'h0000_0000, 5'd0,  1,  1'b1, ST_OK},
      '{OP_READ,     32'h0000_0000, 5'd0,  1,  1'b1, ST_EMPTY},
      '{OP_INS_TAIL, 32'hA5A5_0000, 5'd0,  16, 1'b0, ST_OK},
      '{OP_INS_HEAD, 32'h0000_0001, 5'd0,  1,  1'b1, ST_FULL},
      '{OP_INS_TAIL, 32'h0000_0001, 5'd0,  1,  1'b1, ST_FULL},
      '{OP_INS_POS,  32'h0000_0001, 5'd17, 1,  1'b1, ST_FULL},
      '{OP_READ,     32'h0000_0000, 5'd0,  1,  1'b0, ST_OK},
      '{OP_DEL_POS,  32'h0000_0000, 5'd17, 1,  1'b1, ST_BOUND},
      '{OP_DEL_POS,  32'h0000_0000, 5'd16, 1,  1'b1, ST_OK}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (k = 0; k < NUM_ROWS; k++) begin
      for (j = 0; j < dir_rows[k].rep; j++) begin
        send_item(dir_rows[k].op, dir_rows[k].value + j, dir_rows[k].position,
                  dir_rows[k].typed, dir_rows[k].status);
        idle_gap(1'b0);
      end
    end
    wait_all_results();

    // random walk between empty and full, with reads and bad codes mixed in
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (list_len == CAPACITY) filling = 1'b0;
      else if (list_len == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) < 4) filling = ~filling;

      r = $urandom_range(0, 99);
      if (r < 2) begin
        op = OP_UNUSED;
      end else if (r < 14) begin
        op = OP_READ;
      end else if ($urandom_range(0, 99) < (filling ? 70 : 30)) begin
        r = $urandom_range(0, 2);
        op = (r == 0) ? OP_INS_HEAD : (r == 1) ? OP_INS_TAIL : OP_INS_POS;
      end else begin
        r = $urandom_range(0, 2);
        op = (r == 0) ? OP_DEL_HEAD : (r == 1) ? OP_DEL_TAIL : OP_DEL_POS;
      end

      if ($urandom_range(0, 99) < 15) position = POS_W'($urandom);
      else if (op == OP_INS_POS) position = POS_W'($urandom_range(1, list_len + 1));
      else position = POS_W'($urandom_range(1, (list_len == 0) ? 1 : list_len));

      if ($urandom_range(0, 99) < 10) begin
        case ($urandom_range(0, 3))
          0: value = 32'h8000_0000;
          1: value = 32'h7FFF_FFFF;
          2: value = 32'h0000_0000;
          default: value = 32'hFFFF_FFFF;
        endcase
      end else begin
        value = $urandom;
      end

      send_item(op, value, position, 1'b0, ST_OK);
      if (n == RAND_ITEMS / 2) wait_all_results();
      else idle_gap(n >= 60 && n < 120);
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("bounded_ordered_list_engine_core test passed");
    end else begin
      $display("bounded_ordered_list_engine_core test failed");
    end
    $finish;
  end

endmodule

/* bounded_ordered_list_engine_core.f */
hdl/bole_pkg.sv
hdl/bole_ctrl.sv
hdl/bole_dp.sv
hdl/bounded_ordered_list_engine_core.sv
hdl/bole_chk.sv
bench/testbench.sv
